// ===== rtl/lesf_pkg.sv =====
// Package for the largest empty square finder.
// Holds the configuration and result types, register indexes and reset values.
// No dependencies; every other file but lesf_ram imports it.
package lesf_pkg;

   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 11;

   localparam logic [CSR_INDEX_W-1:0] CSR_OBSTACLE_CHAR = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ROW_WIDTH     = 1'd1;

   localparam logic [7:0]  OBSTACLE_CHAR_RESET = 8'd111;
   localparam logic [10:0] ROW_WIDTH_RESET     = 11'd1024;

   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 32;

   typedef struct packed {
      logic [7:0]  obstacle_char;
      logic [10:0] row_width;
   } lesf_cfg_type;

   typedef struct packed {
      logic [9:0]  left_col;
      logic [9:0]  top_row;
      logic [10:0] square_size;
   } lesf_result_type;

endpackage

// ===== rtl/lesf_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module lesf_ram #(
   parameter int WIDTH = 11,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ===== rtl/lesf_cell_pipe.sv =====
// Two-stage cell pipeline: position counters and line-buffer read, then the
// three-way minimum, best-square tracking and line-buffer write-back.
// Depends on lesf_pkg and lesf_ram.
module lesf_cell_pipe #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic                     clock,
   input  logic                     reset,
   input  lesf_pkg::lesf_cfg_type   cfg,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  logic [7:0]               in_char,
   input  logic                     in_last,
   input  logic                     res_busy,
   output logic                     res_valid,
   output lesf_pkg::lesf_result_type res
);
   import lesf_pkg::*;

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int ROW_W = $clog2(MAX_HEIGHT);
   localparam int VAL_W = $clog2(MAX_WIDTH + 1);

   // Stage 0 counters.
   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [31:0]      width_eff;
   logic             accept;

   // Stage 1 registers.
   logic             s1_valid_ff, s1_valid_in;
   logic [COL_W-1:0] s1_col_ff;
   logic [ROW_W-1:0] s1_row_ff;
   logic             s1_obst_ff;
   logic             s1_last_ff;
   logic             fwd_ff, fwd_in;
   logic [VAL_W-1:0] fwd_data_ff;
   logic [VAL_W-1:0] left_ff;
   logic [VAL_W-1:0] diag_ff;
   logic [VAL_W-1:0] best_size_ff, best_size_in;
   logic [ROW_W-1:0] best_row_ff, best_row_in;
   logic [COL_W-1:0] best_col_ff, best_col_in;

   logic             stall;
   logic             s1_fire;
   logic [VAL_W-1:0] rd_data;
   logic [VAL_W-1:0] above;
   logic [VAL_W-1:0] min_al;
   logic [VAL_W-1:0] min3;
   logic [31:0]      value32;
   logic [VAL_W-1:0] value;
   logic [31:0]      size32, row32, col32;

   // A last cell waiting for a free output register holds the pipe.
   assign stall    = s1_valid_ff && s1_last_ff && res_busy;
   assign s1_fire  = s1_valid_ff && !stall;
   assign in_ready = !stall;
   assign accept   = in_valid && in_ready;

   always_comb begin
      width_eff = 32'(cfg.row_width);
      if (width_eff == 32'd0) begin
         width_eff = 32'd1;
      end else if (width_eff > 32'(MAX_WIDTH)) begin
         width_eff = 32'(MAX_WIDTH);
      end

      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (in_last) begin
            col_in = '0;
            row_in = '0;
         end else if (32'(col_ff) + 32'd1 >= width_eff) begin
            col_in = '0;
            if (32'(row_ff) + 32'd1 < 32'(MAX_HEIGHT)) begin
               row_in = row_ff + ROW_W'(1);
            end
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
   end

   always_comb begin
      above  = fwd_ff ? fwd_data_ff : rd_data;
      min_al = (above < left_ff) ? above : left_ff;
      min3   = (min_al < diag_ff) ? min_al : diag_ff;
      if (s1_obst_ff) begin
         value32 = 32'd0;
      end else if (s1_row_ff == '0 || s1_col_ff == '0) begin
         value32 = 32'd1;
      end else begin
         value32 = 32'(min3) + 32'd1;
      end
      // The top edge of a square never lies above row zero.
      if (value32 > 32'(s1_row_ff) + 32'd1) begin
         value32 = 32'(s1_row_ff) + 32'd1;
      end
      value = value32[VAL_W-1:0];

      best_size_in = best_size_ff;
      best_row_in  = best_row_ff;
      best_col_in  = best_col_ff;
      if (value > best_size_ff) begin
         best_size_in = value;
         best_row_in  = s1_row_ff - ROW_W'(value - VAL_W'(1));
         best_col_in  = s1_col_ff - COL_W'(value - VAL_W'(1));
      end

      size32 = 32'(best_size_in);
      row32  = 32'(best_row_in);
      col32  = 32'(best_col_in);
      res.square_size = size32[10:0];
      res.top_row     = row32[9:0];
      res.left_col    = col32[9:0];
      res_valid       = s1_fire && s1_last_ff;

      s1_valid_in = stall ? s1_valid_ff : accept;
      // A write to the entry being read in the same cycle is forwarded.
      fwd_in = s1_fire && (s1_col_ff == col_ff);
   end

   lesf_ram #(
      .WIDTH (VAL_W),
      .DEPTH (MAX_WIDTH)
   ) u_line_buf (
      .clock   (clock),
      .wr_en   (s1_fire),
      .wr_addr (s1_col_ff),
      .wr_data (value),
      .rd_en   (accept),
      .rd_addr (col_ff),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         row_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         best_size_ff <= '0;
         best_row_ff  <= '0;
         best_col_ff  <= '0;
      end else begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         s1_valid_ff <= s1_valid_in;
         if (s1_fire) begin
            if (s1_last_ff) begin
               best_size_ff <= '0;
               best_row_ff  <= '0;
               best_col_ff  <= '0;
            end else begin
               best_size_ff <= best_size_in;
               best_row_ff  <= best_row_in;
               best_col_ff  <= best_col_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_col_ff   <= col_ff;
         s1_row_ff   <= row_ff;
         s1_obst_ff  <= (in_char == cfg.obstacle_char);
         s1_last_ff  <= in_last;
         fwd_ff      <= fwd_in;
         fwd_data_ff <= value;
      end
      if (s1_fire) begin
         left_ff <= value;
         diag_ff <= above;
      end
   end

endmodule

// ===== rtl/largest_empty_square_finder_unit.sv =====
// Largest empty square finder: grid cells stream in raster order, one per beat,
// and the beat marked tlast yields one result beat with the square's size and
// top-left corner. The unit takes one cell per clock cycle unless stalled; the
// result beat is registered into the output register as the last cell leaves
// stage 1 of the cell pipe. The only stall holds cell beats back while a grid's
// last cell waits to report and the output register still holds a result that
// the receiver does not take in that cycle. The previous row lives in a
// one-read, one-write line buffer of MAX_WIDTH entries, read as a cell is
// accepted and written back from stage 1; it needs no clearing after reset.
// Depends on lesf_pkg, lesf_cell_pipe and lesf_ram.
module largest_empty_square_finder_unit #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [lesf_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [lesf_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [lesf_pkg::REQ_DATA_W-1:0]     req_tdata,  // [7:0] cell_char
   input  logic                                req_tlast,  // last_cell
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [10:0] square_size, [20:11] top_row, [30:21] left_col, [31] zero
   output logic [lesf_pkg::RSP_DATA_W-1:0]     rsp_tdata
);
   import lesf_pkg::*;

   lesf_cfg_type    cfg_ff, cfg_in;
   logic            rsp_valid_ff, rsp_valid_in;
   lesf_result_type rsp_ff;
   logic            res_valid;
   lesf_result_type res;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_OBSTACLE_CHAR: cfg_in.obstacle_char = csr_wdata[7:0];
            CSR_ROW_WIDTH:     cfg_in.row_width     = csr_wdata;
            default:           cfg_in = cfg_ff;
         endcase
      end

      if (res_valid) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   lesf_cell_pipe #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_cell_pipe (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_char   (req_tdata[7:0]),
      .in_last   (req_tlast),
      .res_busy  (rsp_valid_ff && !rsp_tready),
      .res_valid (res_valid),
      .res       (res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.obstacle_char <= OBSTACLE_CHAR_RESET;
         cfg_ff.row_width     <= ROW_WIDTH_RESET;
         rsp_valid_ff         <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid) begin
         rsp_ff <= res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_ff};

endmodule

// ===== bench/testbench.sv =====
// Self-checking bench for largest_empty_square_finder_unit: streams grids of cells,
// predicts each grid's largest empty square and checks every result beat.
// Depends on lesf_pkg and the unit itself, and through the unit on lesf_cell_pipe and lesf_ram.
module testbench;
   import lesf_pkg::*;

   localparam int GRID_MAX_W    = 1024;
   localparam int GRID_MAX_H    = 1024;
   localparam int SETTLE_CYCLES = 4;
   localparam int STALL_LIMIT   = 2000;
   localparam int RANDOM_CELLS  = 900;
   localparam int WARM_CELLS    = 8;
   localparam int PRINT_CAP     = 40;

   // Tracks the grid exactly as the unit should, and holds the squares still owed.
   class square_tracker;
      lesf_cfg_type    cfg;
      logic [10:0]     above_vals [GRID_MAX_W];
      logic [10:0]     left_val;
      logic [10:0]     diag_val;
      logic [10:0]     best_size;
      logic [9:0]      col_cnt;
      logic [9:0]      row_cnt;
      logic [9:0]      best_row;
      logic [9:0]      best_col;
      lesf_result_type expected_squares [$];
      int              mismatches;
      int              checked;

      function new();
         cfg.obstacle_char = OBSTACLE_CHAR_RESET;
         cfg.row_width     = ROW_WIDTH_RESET;
         foreach (above_vals[i]) above_vals[i] = '0;
         mismatches = 0;
         checked    = 0;
         start_grid();
      endfunction

      function void start_grid();
         left_val  = '0;
         diag_val  = '0;
         col_cnt   = '0;
         row_cnt   = '0;
         best_size = '0;
         best_row  = '0;
         best_col  = '0;
      endfunction

      function int pending();
         return expected_squares.size();
      endfunction

      function void note_config(input logic [CSR_INDEX_W-1:0] idx,
                                input logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_OBSTACLE_CHAR: cfg.obstacle_char = data[7:0];
            CSR_ROW_WIDTH:     cfg.row_width     = data;
            default: ;
         endcase
      endfunction

      function void score_cell(input logic [7:0] ch, input logic last);
         int unsigned     w;
         int unsigned     c;
         int unsigned     r;
         int unsigned     above;
         int unsigned     value;
         int unsigned     lo;
         lesf_result_type sq;
         w = 32'(cfg.row_width);
         if (w < 1) w = 1;
         if (w > GRID_MAX_W) w = GRID_MAX_W;
         c = 32'(col_cnt);
         r = 32'(row_cnt);
         if (c >= GRID_MAX_W) c = GRID_MAX_W - 1;
         above = 32'(above_vals[c]);
         if (c == 0) left_val = '0;
         if (ch == cfg.obstacle_char) begin
            value = 0;
         end else if (r == 0 || c == 0) begin
            value = 1;
         end else begin
            lo = above;
            if (32'(left_val) < lo) lo = 32'(left_val);
            if (32'(diag_val) < lo) lo = 32'(diag_val);
            value = lo + 1;
         end
         // Once the row index saturates, keep the top edge from going above row 0.
         if (value > r + 1) value = r + 1;
         if (value > 32'(best_size)) begin
            best_size = 11'(value);
            best_row  = 10'(r + 1 - value);
            best_col  = 10'(c + 1 - value);
         end
         above_vals[c] = 11'(value);
         diag_val      = 11'(above);
         left_val      = 11'(value);
         if (c + 1 >= w) begin
            col_cnt = '0;
            if (r + 1 < GRID_MAX_H) row_cnt = 10'(r + 1);
         end else begin
            col_cnt = 10'(c + 1);
         end
         if (last) begin
            sq.square_size = best_size;
            sq.top_row     = best_row;
            sq.left_col    = best_col;
            expected_squares.push_back(sq);
            start_grid();
         end
      endfunction

      task report_mismatch(input string what, input logic [31:0] got,
                           input logic [31:0] want);
         mismatches++;
         if (mismatches <= PRINT_CAP)
            $display("MISMATCH result %0d: %s got %0d expected %0d",
                     checked, what, got, want);
      endtask

      task check_result(input logic [RSP_DATA_W-1:0] data);
         lesf_result_type got;
         lesf_result_type want;
         got = data[30:0];
         checked++;
         if (data[31] !== 1'b0) report_mismatch("padding bit", 32'(data[31]), 0);
         if (expected_squares.size() == 0) begin
            report_mismatch("result beat with no grid ended", data, 0);
         end else begin
            want = expected_squares.pop_front();
            if (got.square_size !== want.square_size)
               report_mismatch("square_size", 32'(got.square_size),
                               32'(want.square_size));
            if (got.top_row !== want.top_row)
               report_mismatch("top_row", 32'(got.top_row), 32'(want.top_row));
            if (got.left_col !== want.left_col)
               report_mismatch("left_col", 32'(got.left_col), 32'(want.left_col));
         end
      endtask
   endclass

   logic                   clock;
   logic                   reset      = 1'b1;
   logic                   csr_valid  = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index  = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata  = '0;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata  = '0;   // [7:0] cell_char
   logic                   req_tlast  = 1'b0; // last_cell
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   // [10:0] square_size, [20:11] top_row, [30:21] left_col, [31] zero
   logic [RSP_DATA_W-1:0]  rsp_tdata;

   square_tracker squares = new();

   int send_gap_pct = 31;
   int recv_gap_pct = 73;
   int cells_sent   = 0;
   int grids_sent   = 0;
   int reg_writes   = 0;
   int quiet_cycles = 0;

   largest_empty_square_finder_unit #(
      .MAX_WIDTH  (GRID_MAX_W),
      .MAX_HEIGHT (GRID_MAX_H)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_gap_pct);
   end

   // Beats are sampled at the edge, before any driver update of that edge lands.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) squares.check_result(rsp_tdata);
         if (req_tvalid && req_tready) squares.score_cell(req_tdata[7:0], req_tlast);
         if (csr_valid && csr_ready) squares.note_config(csr_index, csr_wdata);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("timeout: no beat moved for %0d cycles", STALL_LIMIT);
         $display("largest_empty_square_finder_unit regression: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_cell(input logic [7:0] ch, input logic last);
      while ($urandom_range(99) < send_gap_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= ch;
      req_tlast  <= last;
      do @(posedge clock); while (req_tready !== 1'b1);
      cells_sent++;
      if (last) grids_sent++;
   endtask

   task automatic hold_until_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (squares.pending() != 0);
   endtask

   // The unit still writes back the line buffer after a cell is accepted, so let it settle.
   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      hold_until_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (csr_ready !== 1'b1);
      csr_valid <= 1'b0;
      reg_writes++;
   endtask

   task automatic send_free_cells(input int count, input logic end_grid);
      int i;
      for (i = 0; i < count; i++)
         send_cell(8'h2e, end_grid && (i == count - 1));
   endtask

   task automatic run_directed();
      int i;
      // A short first grid writes the line-buffer entries that the directed grids
      // below read back after the row width grows.
      for (i = 0; i < WARM_CELLS; i++)
         send_cell(i == WARM_CELLS - 1 ? 8'h2e : OBSTACLE_CHAR_RESET, i == WARM_CELLS - 1);
      // Obstacle code 0 with the unused upper data bits set; width 0 behaves as 1.
      write_reg(CSR_OBSTACLE_CHAR, 11'h700);
      write_reg(CSR_ROW_WIDTH, 11'd0);
      send_cell(8'h00, 1'b0);
      send_cell(8'h00, 1'b0);
      send_cell(8'h00, 1'b1);
      // Oversized width clamps; all cells free, so the first one wins the tie.
      write_reg(CSR_OBSTACLE_CHAR, 11'd255);
      write_reg(CSR_ROW_WIDTH, 11'd2047);
      send_cell(8'h00, 1'b0);
      send_cell(8'h7f, 1'b0);
      send_cell(8'h80, 1'b0);
      send_cell(8'hfe, 1'b1);
      write_reg(CSR_OBSTACLE_CHAR, 11'("X"));
      write_reg(CSR_ROW_WIDTH, 11'd3);
      send_cell("X", 1'b0);
      send_free_cells(11, 1'b1);
      // Width shrinks and then grows in the middle of one grid.
      write_reg(CSR_ROW_WIDTH, 11'd4);
      send_free_cells(6, 1'b0);
      write_reg(CSR_ROW_WIDTH, 11'd2);
      send_free_cells(4, 1'b0);
      write_reg(CSR_ROW_WIDTH, 11'd6);
      send_free_cells(8, 1'b1);
      // A tall single-column grid pushes the row index into saturation.
      write_reg(CSR_OBSTACLE_CHAR, 11'(OBSTACLE_CHAR_RESET));
      write_reg(CSR_ROW_WIDTH, 11'd1);
      for (i = 0; i < GRID_MAX_H + 6; i++)
         send_cell(i == GRID_MAX_H + 3 ? 8'hff : OBSTACLE_CHAR_RESET, i == GRID_MAX_H + 5);
      write_reg(CSR_ROW_WIDTH, 11'd1024);
      send_cell(8'h00, 1'b1);
   endtask

   task automatic random_grid();
      int          ncells;
      int          density;
      int          i;
      logic [7:0]  ch;
      logic [10:0] width;
      if ($urandom_range(3) == 0)
         write_reg(CSR_OBSTACLE_CHAR, 11'($urandom_range(2047)));
      if ($urandom_range(3) == 0) begin
         case ($urandom_range(9))
            0:       width = 11'd0;
            1:       width = 11'($urandom_range(1025, 2047));
            2:       width = 11'($urandom_range(13, 1024));
            default: width = 11'($urandom_range(1, 12));
         endcase
         write_reg(CSR_ROW_WIDTH, width);
      end
      case ($urandom_range(9))
         0:       ncells = 1;
         8, 9:    ncells = $urandom_range(41, 120);
         default: ncells = $urandom_range(2, 40);
      endcase
      case ($urandom_range(5))
         0:       density = 0;
         1:       density = 100;
         default: density = $urandom_range(5, 60);
      endcase
      for (i = 0; i < ncells; i++) begin
         if ($urandom_range(99) < density) begin
            ch = squares.cfg.obstacle_char;
         end else begin
            do ch = 8'($urandom_range(255)); while (ch == squares.cfg.obstacle_char);
         end
         if ($urandom_range(63) == 0) hold_until_drained();
         send_cell(ch, i == ncells - 1);
      end
   endtask

   initial begin
      int directed_cells;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      run_directed();
      directed_cells = cells_sent;
      while (cells_sent - directed_cells < RANDOM_CELLS) begin
         if (cells_sent - directed_cells < RANDOM_CELLS / 3) begin
            send_gap_pct = 31;
            recv_gap_pct = 73;
         end else if (cells_sent - directed_cells < 2 * RANDOM_CELLS / 3) begin
            send_gap_pct = 73;
            recv_gap_pct = 31;
         end else begin
            send_gap_pct = 0;
            recv_gap_pct = 0;
         end
         random_grid();
      end
      hold_until_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (squares.pending() != 0)
         squares.report_mismatch("results never delivered", 0, squares.pending());
      $display("Streamed %0d cells in %0d grids with %0d register writes; %0d results checked.",
               cells_sent, grids_sent, reg_writes, squares.checked);
      $display("Covered clamped widths, mid-grid width changes, row saturation and %0d mismatches.",
               squares.mismatches);
      if (squares.mismatches == 0) begin
         $display("largest_empty_square_finder_unit regression: pass");
      end else begin
         $display("largest_empty_square_finder_unit regression: fail");
      end
      $finish;
   end

endmodule
